// ----- hw/rtl/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

  localparam int WORD_BITS = 32;
  localparam int DW        = 2 * WORD_BITS;
  localparam int KW        = $clog2(DW);
  localparam int CW        = KW + 1;

  typedef enum logic [2:0] {
    FN_ADD  = 3'd0,
    FN_SUB  = 3'd1,
    FN_MUL  = 3'd2,
    FN_DIV  = 3'd3,
    FN_INC  = 3'd4,
    FN_DEC  = 3'd5,
    FN_CMP  = 3'd6,
    FN_NORM = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_DIVZ = 2'd1,
    STAT_OVF  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    UK_GCD = 2'd0,
    UK_DIV = 2'd1,
    UK_MUL = 2'd2
  } ukind_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RA_G, S_RA_N, S_RA_D,
    S_RB_G, S_RB_N, S_RB_D,
    S_OP,
    S_AS_G, S_AS_FA, S_AS_FB, S_AS_L, S_AS_MA, S_AS_MB, S_AS_SUM,
    S_MD_N, S_MD_D,
    S_CMP_X, S_CMP_Y, S_CMP_OUT,
    S_RR_G, S_RR_N, S_RR_D,
    S_FIN
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rational_arith_unit.sv -----
// ----------------------------------------------------------------------------
// rational_arith_unit
// Exact add, subtract, multiply, divide, step, compare and normalize on
// signed fractions, with every fraction result reduced by the gcd.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result comes
// back as a one-cycle beat marked by out_valid, which the receiver cannot
// stall. All gcd, divide and multiply work goes through one shared serial
// unit: a binary gcd that retires one shift or subtract per cycle, a
// restoring divider at one quotient bit per cycle and a shift-add
// multiplier at one multiplier bit per cycle. An item runs up to fifteen
// such jobs in sequence (add and subtract); an item with a zero
// denominator runs no job and is answered with a divide-by-zero status.
`default_nettype none

module rational_arith_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_func,
  input  wire logic signed [rau_pkg::WORD_BITS-1:0] in_a_num,
  input  wire logic signed [rau_pkg::WORD_BITS-1:0] in_a_den,
  input  wire logic signed [rau_pkg::WORD_BITS-1:0] in_b_num,
  input  wire logic signed [rau_pkg::WORD_BITS-1:0] in_b_den,
  output logic             out_valid,
  output logic signed [rau_pkg::WORD_BITS-1:0] out_res_num,
  output logic [rau_pkg::WORD_BITS-2:0] out_res_den,
  output logic [1:0]       out_status,
  output logic             out_less,
  output logic             out_equal
);

  localparam int W  = rau_pkg::WORD_BITS;
  localparam int DW = rau_pkg::DW;
  localparam int KW = rau_pkg::KW;
  localparam int CW = rau_pkg::CW;
  localparam logic [DW-1:0] LIM = DW'(1) << (W - 1);

  rau_pkg::state_t state_r, state_nxt;
  rau_pkg::func_t  func_r;
  logic            wait_r;

  logic          an_r, bn_r, rn_r;
  logic [W-1:0]  am_r, ad_r, bm_r, bd_r;
  logic [DW-1:0] rm_r, rd_r, g_r, t1_r, t2_r;

  // Shared serial unit.
  rau_pkg::ukind_t u_kind_r, u_kind;
  logic          u_start, u_act_r, u_done_r, u_fin;
  logic [DW-1:0] u_opa, u_opb, u_x_r, u_y_r, u_res_r;
  logic [DW:0]   u_acc_r;
  logic [KW-1:0] u_k_r;
  logic [CW-1:0] u_cnt_r;
  logic [DW:0]   div_sh, div_sub;
  logic          div_bit;
  logic [DW-1:0] mul_add;

  logic          uses_b, den_err, is_md, is_step;
  logic [W-1:0]  a_nm, a_dm, b_nm, b_dm;
  logic [DW:0]   sum_as, sum_inc;
  logic          cmp_less, cmp_eq, xn, yn, ovf;

  function automatic logic [DW:0] sm_add(input logic xn_i, input logic [DW-1:0] xm,
                                         input logic yn_i, input logic [DW-1:0] ym);
    logic [DW:0] r;
    if (xn_i == yn_i) begin
      r = {xn_i, xm + ym};
    end else if (xm >= ym) begin
      r = {xn_i, xm - ym};
    end else begin
      r = {yn_i, ym - xm};
    end
    return r;
  endfunction

  assign uses_b  = (in_func <= 3'(rau_pkg::FN_DIV)) || (in_func == 3'(rau_pkg::FN_CMP));
  assign den_err = (in_a_den == '0) || (uses_b && (in_b_den == '0));
  assign a_nm    = in_a_num[W-1] ? (~in_a_num + W'(1)) : in_a_num;
  assign a_dm    = in_a_den[W-1] ? (~in_a_den + W'(1)) : in_a_den;
  assign b_nm    = in_b_num[W-1] ? (~in_b_num + W'(1)) : in_b_num;
  assign b_dm    = in_b_den[W-1] ? (~in_b_den + W'(1)) : in_b_den;

  assign is_md   = (func_r == rau_pkg::FN_MUL) || (func_r == rau_pkg::FN_DIV);
  assign is_step = (func_r == rau_pkg::FN_INC) || (func_r == rau_pkg::FN_DEC);

  assign sum_as  = sm_add(an_r, t1_r, bn_r ^ (func_r == rau_pkg::FN_SUB), t2_r);
  assign sum_inc = sm_add(an_r, DW'(am_r), func_r == rau_pkg::FN_DEC, DW'(ad_r));

  assign xn = an_r && (t1_r != '0);
  assign yn = bn_r && (t2_r != '0);
  always_comb begin
    cmp_eq   = (xn == yn) && (t1_r == t2_r);
    if (xn != yn) begin
      cmp_less = xn;
    end else if (xn) begin
      cmp_less = t1_r > t2_r;
    end else begin
      cmp_less = t1_r < t2_r;
    end
  end

  assign ovf = (rd_r > LIM - DW'(1)) || (rn_r ? (rm_r > LIM) : (rm_r > LIM - DW'(1)));

  // Next state and unit launch.
  always_comb begin
    state_nxt = state_r;
    u_start   = 1'b0;
    u_kind    = rau_pkg::UK_DIV;
    u_opa     = '0;
    u_opb     = '0;
    unique case (state_r)
      rau_pkg::S_IDLE: begin
        if (start && !den_err) state_nxt = rau_pkg::S_RA_G;
      end
      rau_pkg::S_RA_G: begin
        u_kind = rau_pkg::UK_GCD; u_opa = DW'(am_r); u_opb = DW'(ad_r);
        if (am_r == '0) begin
          state_nxt = (func_r <= rau_pkg::FN_DIV || func_r == rau_pkg::FN_CMP) ?
                      rau_pkg::S_RB_G : rau_pkg::S_OP;
        end else begin
          u_start = !wait_r;
          if (u_done_r) state_nxt = rau_pkg::S_RA_N;
        end
      end
      rau_pkg::S_RA_N: begin
        u_opa = DW'(am_r); u_opb = g_r; u_start = !wait_r;
        if (u_done_r) state_nxt = rau_pkg::S_RA_D;
      end
      rau_pkg::S_RA_D: begin
        u_opa = DW'(ad_r); u_opb = g_r; u_start = !wait_r;
        if (u_done_r) begin
          state_nxt = (func_r <= rau_pkg::FN_DIV || func_r == rau_pkg::FN_CMP) ?
                      rau_pkg::S_RB_G : rau_pkg::S_OP;
        end
      end
      rau_pkg::S_RB_G: begin
        u_kind = rau_pkg::UK_GCD; u_opa = DW'(bm_r); u_opb = DW'(bd_r);
        if (bm_r == '0) begin
          state_nxt = rau_pkg::S_OP;
        end else begin
          u_start = !wait_r;
          if (u_done_r) state_nxt = rau_pkg::S_RB_N;
        end
      end
      rau_pkg::S_RB_N: begin
        u_opa = DW'(bm_r); u_opb = g_r; u_start = !wait_r;
        if (u_done_r) state_nxt = rau_pkg::S_RB_D;
      end
      rau_pkg::S_RB_D: begin
        u_opa = DW'(bd_r); u_opb = g_r; u_start = !wait_r;
        if (u_done_r) state_nxt = rau_pkg::S_OP;
      end
      rau_pkg::S_OP: begin
        case (func_r)
          rau_pkg::FN_ADD, rau_pkg::FN_SUB: state_nxt = rau_pkg::S_AS_G;
          rau_pkg::FN_MUL: state_nxt = rau_pkg::S_MD_N;
          rau_pkg::FN_DIV: state_nxt = (bm_r == '0) ? rau_pkg::S_IDLE : rau_pkg::S_MD_N;
          rau_pkg::FN_CMP: state_nxt = rau_pkg::S_CMP_X;
          default:         state_nxt = rau_pkg::S_RR_G;
        endcase
      end
      rau_pkg::S_AS_G: begin
        u_kind = rau_pkg::UK_GCD; u_opa = DW'(ad_r); u_opb = DW'(bd_r);
        u_start = !wait_r;
        if (u_done_r) state_nxt = rau_pkg::S_AS_FA;
      end
      rau_pkg::S_AS_FA: begin
        u_opa = DW'(bd_r); u_opb = g_r; u_start = !wait_r;
        if (u_done_r) state_nxt = rau_pkg::S_AS_FB;
      end
      rau_pkg::S_AS_FB: begin
        u_opa = DW'(ad_r); u_opb = g_r; u_start = !wait_r;
        if (u_done_r) state_nxt = rau_pkg::S_AS_L;
      end
      rau_pkg::S_AS_L: begin
        u_kind = rau_pkg::UK_MUL; u_opa = DW'(bd_r); u_opb = t2_r;
        u_start = !wait_r;
        if (u_done_r) state_nxt = rau_pkg::S_AS_MA;
      end
      rau_pkg::S_AS_MA: begin
        u_kind = rau_pkg::UK_MUL; u_opa = DW'(am_r); u_opb = t1_r;
        u_start = !wait_r;
        if (u_done_r) state_nxt = rau_pkg::S_AS_MB;
      end
      rau_pkg::S_AS_MB: begin
        u_kind = rau_pkg::UK_MUL; u_opa = DW'(bm_r); u_opb = t2_r;
        u_start = !wait_r;
        if (u_done_r) state_nxt = rau_pkg::S_AS_SUM;
      end
      rau_pkg::S_AS_SUM: state_nxt = rau_pkg::S_RR_G;
      rau_pkg::S_MD_N: begin
        u_kind = rau_pkg::UK_MUL; u_opa = DW'(am_r);
        u_opb = (func_r == rau_pkg::FN_MUL) ? DW'(bm_r) : DW'(bd_r);
        u_start = !wait_r;
        if (u_done_r) state_nxt = rau_pkg::S_MD_D;
      end
      rau_pkg::S_MD_D: begin
        u_kind = rau_pkg::UK_MUL; u_opa = DW'(ad_r);
        u_opb = (func_r == rau_pkg::FN_MUL) ? DW'(bd_r) : DW'(bm_r);
        u_start = !wait_r;
        if (u_done_r) state_nxt = rau_pkg::S_RR_G;
      end
      rau_pkg::S_CMP_X: begin
        u_kind = rau_pkg::UK_MUL; u_opa = DW'(am_r); u_opb = DW'(bd_r);
        u_start = !wait_r;
        if (u_done_r) state_nxt = rau_pkg::S_CMP_Y;
      end
      rau_pkg::S_CMP_Y: begin
        u_kind = rau_pkg::UK_MUL; u_opa = DW'(bm_r); u_opb = DW'(ad_r);
        u_start = !wait_r;
        if (u_done_r) state_nxt = rau_pkg::S_CMP_OUT;
      end
      rau_pkg::S_CMP_OUT: state_nxt = rau_pkg::S_IDLE;
      rau_pkg::S_RR_G: begin
        u_kind = rau_pkg::UK_GCD; u_opa = rm_r; u_opb = rd_r;
        if (rm_r == '0) begin
          state_nxt = rau_pkg::S_FIN;
        end else begin
          u_start = !wait_r;
          if (u_done_r) state_nxt = rau_pkg::S_RR_N;
        end
      end
      rau_pkg::S_RR_N: begin
        u_opa = rm_r; u_opb = g_r; u_start = !wait_r;
        if (u_done_r) state_nxt = rau_pkg::S_RR_D;
      end
      rau_pkg::S_RR_D: begin
        u_opa = rd_r; u_opb = g_r; u_start = !wait_r;
        if (u_done_r) state_nxt = rau_pkg::S_FIN;
      end
      rau_pkg::S_FIN: state_nxt = rau_pkg::S_IDLE;
      default: state_nxt = rau_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rau_pkg::S_IDLE;
      wait_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (u_done_r) begin
        wait_r <= 1'b0;
      end else if (u_start) begin
        wait_r <= 1'b1;
      end
    end
  end

  // Serial unit datapath.
  assign div_sh  = {u_acc_r[DW-1:0], u_x_r[DW-1]};
  assign div_sub = div_sh - {1'b0, u_y_r};
  assign div_bit = !div_sub[DW];
  assign mul_add = u_acc_r[DW-1:0] + (u_y_r[0] ? u_x_r : '0);

  // The last working cycle of the running job.
  always_comb begin
    u_fin = 1'b0;
    if (u_act_r && !u_start) begin
      case (u_kind_r)
        rau_pkg::UK_GCD: u_fin = (u_x_r == '0) || (u_y_r == '0);
        rau_pkg::UK_DIV: u_fin = (u_cnt_r == CW'(DW - 1));
        default:         u_fin = (u_cnt_r == CW'(W - 1));
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_act_r  <= 1'b0;
      u_done_r <= 1'b0;
    end else begin
      u_done_r <= u_fin;
      if (u_start) begin
        u_act_r <= 1'b1;
      end else if (u_fin) begin
        u_act_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (u_start) begin
      u_kind_r <= u_kind;
      u_x_r    <= u_opa;
      u_y_r    <= u_opb;
      u_acc_r  <= '0;
      u_k_r    <= '0;
      u_cnt_r  <= '0;
    end else if (u_act_r) begin
      u_cnt_r <= u_cnt_r + CW'(1);
      case (u_kind_r)
        rau_pkg::UK_GCD: begin
          // Binary gcd: common factors of two are counted in u_k_r.
          if (u_x_r == '0) begin
            u_res_r <= u_y_r << u_k_r;
          end else if (u_y_r == '0) begin
            u_res_r <= u_x_r << u_k_r;
          end else if (!u_x_r[0] && !u_y_r[0]) begin
            u_x_r <= u_x_r >> 1;
            u_y_r <= u_y_r >> 1;
            u_k_r <= u_k_r + KW'(1);
          end else if (!u_x_r[0]) begin
            u_x_r <= u_x_r >> 1;
          end else if (!u_y_r[0]) begin
            u_y_r <= u_y_r >> 1;
          end else if (u_x_r >= u_y_r) begin
            u_x_r <= u_x_r - u_y_r;
          end else begin
            u_y_r <= u_y_r - u_x_r;
          end
        end
        rau_pkg::UK_DIV: begin
          u_acc_r <= div_bit ? div_sub : div_sh;
          u_x_r   <= {u_x_r[DW-2:0], div_bit};
          u_res_r <= {u_x_r[DW-2:0], div_bit};
        end
        default: begin
          u_acc_r <= {1'b0, mul_add};
          u_res_r <= mul_add;
          u_x_r   <= u_x_r << 1;
          u_y_r   <= u_y_r >> 1;
        end
      endcase
    end
  end

  // Operand and result registers.
  always_ff @(posedge clk) begin
    case (state_r)
      rau_pkg::S_IDLE: begin
        func_r <= rau_pkg::func_t'(in_func);
        an_r   <= in_a_num[W-1] ^ in_a_den[W-1];
        am_r   <= a_nm;
        ad_r   <= a_dm;
        bn_r   <= in_b_num[W-1] ^ in_b_den[W-1];
        bm_r   <= b_nm;
        bd_r   <= b_dm;
      end
      rau_pkg::S_RA_G: begin
        if (am_r == '0) begin
          an_r <= 1'b0;
          ad_r <= W'(1);
        end else if (u_done_r) begin
          g_r <= u_res_r;
        end
      end
      rau_pkg::S_RA_N: if (u_done_r) am_r <= u_res_r[W-1:0];
      rau_pkg::S_RA_D: if (u_done_r) ad_r <= u_res_r[W-1:0];
      rau_pkg::S_RB_G: begin
        if (bm_r == '0) begin
          bn_r <= 1'b0;
          bd_r <= W'(1);
        end else if (u_done_r) begin
          g_r <= u_res_r;
        end
      end
      rau_pkg::S_RB_N: if (u_done_r) bm_r <= u_res_r[W-1:0];
      rau_pkg::S_RB_D: if (u_done_r) bd_r <= u_res_r[W-1:0];
      rau_pkg::S_OP: begin
        rn_r <= is_md ? (an_r ^ bn_r) : (is_step ? sum_inc[DW] : an_r);
        rm_r <= is_step ? sum_inc[DW-1:0] : DW'(am_r);
        rd_r <= DW'(ad_r);
      end
      rau_pkg::S_AS_G:  if (u_done_r) g_r  <= u_res_r;
      rau_pkg::S_AS_FA: if (u_done_r) t1_r <= u_res_r;
      rau_pkg::S_AS_FB: if (u_done_r) t2_r <= u_res_r;
      rau_pkg::S_AS_L:  if (u_done_r) rd_r <= u_res_r;
      rau_pkg::S_AS_MA: if (u_done_r) t1_r <= u_res_r;
      rau_pkg::S_AS_MB: if (u_done_r) t2_r <= u_res_r;
      rau_pkg::S_AS_SUM: begin
        rn_r <= sum_as[DW];
        rm_r <= sum_as[DW-1:0];
      end
      rau_pkg::S_MD_N:  if (u_done_r) rm_r <= u_res_r;
      rau_pkg::S_MD_D:  if (u_done_r) rd_r <= u_res_r;
      rau_pkg::S_CMP_X: if (u_done_r) t1_r <= u_res_r;
      rau_pkg::S_CMP_Y: if (u_done_r) t2_r <= u_res_r;
      rau_pkg::S_RR_G: begin
        if (rm_r == '0) begin
          rn_r <= 1'b0;
          rd_r <= DW'(1);
        end else if (u_done_r) begin
          g_r <= u_res_r;
        end
      end
      rau_pkg::S_RR_N: if (u_done_r) rm_r <= u_res_r;
      rau_pkg::S_RR_D: if (u_done_r) rd_r <= u_res_r;
      default: ;
    endcase
  end

  // Result beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (state_r == rau_pkg::S_IDLE && start && den_err) ||
                   (state_r == rau_pkg::S_OP && func_r == rau_pkg::FN_DIV && bm_r == '0) ||
                   (state_r == rau_pkg::S_CMP_OUT) || (state_r == rau_pkg::S_FIN);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == rau_pkg::S_CMP_OUT) begin
      out_res_num <= '0;
      out_res_den <= '0;
      out_status  <= rau_pkg::STAT_OK;
      out_less    <= cmp_less;
      out_equal   <= cmp_eq;
    end else if (state_r == rau_pkg::S_FIN && !ovf) begin
      out_res_num <= rn_r ? (~rm_r[W-1:0] + W'(1)) : rm_r[W-1:0];
      out_res_den <= rd_r[W-2:0];
      out_status  <= rau_pkg::STAT_OK;
      out_less    <= 1'b0;
      out_equal   <= 1'b0;
    end else begin
      out_res_num <= '0;
      out_res_den <= '0;
      out_status  <= (state_r == rau_pkg::S_FIN) ? rau_pkg::STAT_OVF : rau_pkg::STAT_DIVZ;
      out_less    <= 1'b0;
      out_equal   <= 1'b0;
    end
  end

  assign busy = (state_r != rau_pkg::S_IDLE);

  // A unit result only ever arrives while the sequencer waits for it.
  a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    u_done_r |-> wait_r) else $error("unit result without a pending job");

  a_less_eq_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_less && out_equal)) else $error("less and equal both set");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != rau_pkg::STAT_OK) |-> (out_res_num == '0 && out_res_den == '0))
    else $error("error beat carries a value");

  a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy)) else $error("accepted item was dropped");

endmodule

`default_nettype wire
